// ----- hdl/erm_pkg.sv -----
// Shared types and codes of the extent range mapper.
// Used by erm_front, erm_queue, erm_back and extent_range_mapper.
package erm_pkg;

    localparam int unsigned W = 64;

    // request kinds carried in tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    // configuration register indexes
    localparam logic CFG_VSIZE = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // classified command; a/b/c hold virt_off/len/data_off for loads,
    // and off/clipped end for maps
    typedef struct packed {
        logic         is_map;
        logic         bad;
        logic [3:0]   idx;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] c;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WALK
    } t_state;

endpackage

// ----- hdl/erm_front.sv -----
// Front part: classifies items and clips map ranges to the virtual size.
// Depends on erm_pkg.
module erm_front (
    input  logic                 i_type,
    input  logic [3:0]           i_idx,
    input  logic [erm_pkg::W-1:0] i_ext_virt_off,
    input  logic [erm_pkg::W-1:0] i_ext_len,
    input  logic [erm_pkg::W-1:0] i_ext_data_off,
    input  logic [erm_pkg::W-1:0] i_req_off,
    input  logic [erm_pkg::W-1:0] i_req_len,
    input  logic [erm_pkg::W-1:0] i_vsize,
    output erm_pkg::t_cmd        o_cmd
);
    import erm_pkg::*;

    logic [W-1:0] w_sum;
    logic [W-1:0] w_end;

    assign w_sum = i_req_off + i_req_len;
    assign w_end = (w_sum < i_vsize) ? w_sum : i_vsize;

    always_comb begin
        o_cmd.is_map = (i_type == REQ_MAP);
        o_cmd.idx    = i_idx;
        if (i_type == REQ_MAP) begin
            o_cmd.bad = (i_req_off >= i_vsize) || (w_end <= i_req_off);
            o_cmd.a   = i_req_off;
            o_cmd.b   = w_end;
            o_cmd.c   = '0;
        end else begin
            o_cmd.bad = 1'b0;
            o_cmd.a   = i_ext_virt_off;
            o_cmd.b   = i_ext_len;
            o_cmd.c   = i_ext_data_off;
        end
    end

endmodule

// ----- hdl/erm_queue.sv -----
// Two-entry command queue between the front and back parts.
// Depends on erm_pkg.
module erm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  erm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output erm_pkg::t_cmd o_cmd
);
    import erm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ----- hdl/erm_back.sv -----
// Back part: extent table, range walk sequencer and output register.
// Depends on erm_pkg.
module erm_back #(
    parameter int unsigned MAX_EXTENTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [4:0]            i_ext_count,
    input  logic                  i_q_valid,
    input  erm_pkg::t_cmd         i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_seg_valid,
    output logic                  o_seg_is_overlay,
    output logic [erm_pkg::W-1:0] o_seg_off,
    output logic [erm_pkg::W-1:0] o_seg_len,
    output logic [erm_pkg::W-1:0] o_seg_data_off,
    output logic                  o_seg_last
);
    import erm_pkg::*;

    localparam int unsigned IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);

    // table: start, saturated end, and data start minus virtual start
    logic [W-1:0] r_vs [MAX_EXTENTS];
    logic [W-1:0] r_ve [MAX_EXTENTS];
    logic [W-1:0] r_dm [MAX_EXTENTS];

    t_state       r_state, n_state;
    logic [CW-1:0] r_i, n_i;
    logic [W-1:0] r_pos, n_pos;
    logic [W-1:0] r_end, n_end;

    logic         r_ov, n_ov;
    logic         r_oseg, n_oseg;
    logic         r_ovl, n_ovl;
    logic [W-1:0] r_ooff, n_ooff;
    logic [W-1:0] r_olen, n_olen;
    logic [W-1:0] r_odat, n_odat;
    logic         r_olast, n_olast;

    logic [CW-1:0] w_cnt;
    logic          w_in_tab;
    logic [IW-1:0] w_ri;
    logic [W-1:0]  w_vs, w_ve, w_dm, w_se;
    logic          w_free;
    logic [4:0]    w_idx5;
    logic [IW-1:0] w_lidx;
    logic          w_load;
    logic [W:0]    w_lsum;

    assign w_cnt    = (i_ext_count > 5'(MAX_EXTENTS)) ? CW'(MAX_EXTENTS) : CW'(i_ext_count);
    assign w_in_tab = (r_i < w_cnt);
    assign w_ri     = r_i[IW-1:0];
    assign w_vs     = r_vs[w_ri];
    assign w_ve     = r_ve[w_ri];
    assign w_dm     = r_dm[w_ri];
    assign w_se     = (w_ve > r_end) ? r_end : w_ve;
    assign w_free   = !r_ov || i_ready;

    assign w_idx5 = {1'b0, i_q_cmd.idx};
    assign w_lidx = w_idx5[IW-1:0];
    assign w_lsum = {1'b0, i_q_cmd.a} + {1'b0, i_q_cmd.b};
    assign w_load = o_q_pop && !i_q_cmd.is_map && (w_idx5 < 5'(MAX_EXTENTS));

    // load writes land in the table as the command leaves the queue
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_vs[w_lidx] <= i_q_cmd.a;
            r_ve[w_lidx] <= w_lsum[W] ? '1 : w_lsum[W-1:0];
            r_dm[w_lidx] <= i_q_cmd.c - i_q_cmd.a;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_pos   = r_pos;
        n_end   = r_end;
        n_ov    = r_ov && !i_ready;
        n_oseg  = r_oseg;
        n_ovl   = r_ovl;
        n_ooff  = r_ooff;
        n_olen  = r_olen;
        n_odat  = r_odat;
        n_olast = r_olast;
        o_q_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && w_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.is_map) begin
                        if (i_q_cmd.bad) begin
                            n_ov = 1'b1; n_oseg = 1'b0; n_ovl = 1'b0;
                            n_ooff = '0; n_olen = '0; n_odat = '0; n_olast = 1'b1;
                        end else begin
                            n_pos   = i_q_cmd.a;
                            n_end   = i_q_cmd.b;
                            n_i     = '0;
                            n_state = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                // skip extents that end at or before the start
                if (w_in_tab && (w_ve <= r_pos)) n_i = r_i + 1'b1;
                else n_state = ST_WALK;
            end
            ST_WALK: begin
                if (w_free) begin
                    if (!w_in_tab || (w_vs >= r_end)) begin
                        n_ov = 1'b1; n_oseg = 1'b1; n_ovl = 1'b0;
                        n_ooff = r_pos; n_olen = r_end - r_pos; n_odat = '0;
                        n_olast = 1'b1;
                        n_state = ST_IDLE;
                    end else if (r_pos < w_vs) begin
                        n_ov = 1'b1; n_oseg = 1'b1; n_ovl = 1'b0;
                        n_ooff = r_pos; n_olen = w_vs - r_pos; n_odat = '0;
                        n_olast = 1'b0;
                        n_pos = w_vs;
                    end else begin
                        n_i = r_i + 1'b1;
                        if (r_pos < w_se) begin
                            n_ov = 1'b1; n_oseg = 1'b1; n_ovl = 1'b1;
                            n_ooff = r_pos; n_olen = w_se - r_pos;
                            n_odat = w_dm + r_pos;
                            n_olast = (w_se == r_end);
                            n_pos = w_se;
                            if (w_se == r_end) n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_pos   <= n_pos;
        r_end   <= n_end;
        r_oseg  <= n_oseg;
        r_ovl   <= n_ovl;
        r_ooff  <= n_ooff;
        r_olen  <= n_olen;
        r_odat  <= n_odat;
        r_olast <= n_olast;
    end

    assign o_valid          = r_ov;
    assign o_seg_valid      = r_oseg;
    assign o_seg_is_overlay = r_ovl;
    assign o_seg_off        = r_ooff;
    assign o_seg_len        = r_olen;
    assign o_seg_data_off   = r_odat;
    assign o_seg_last       = r_olast;

endmodule

// ----- hdl/extent_range_mapper.sv -----
// Extent range mapper top level: config registers, front, queue, back.
// Depends on erm_pkg, erm_front, erm_queue, erm_back.
// A map is queued, popped in IDLE, then SEARCH skips extents ending at or before
// its start and WALK registers its first word; an empty, out-of-range or wrapping
// map registers its word straight from IDLE. A load only needs its queue pop. A map
// takes its search and walk steps, each extent left costing at most two (gap, then
// overlay) plus one closing gap; output stalls add to this. Pops happen only in IDLE.
// Reset (i_rst_n low, synchronous): clears registers, queue and sequencer;
// table contents stay undefined until loaded.
module extent_range_mapper #(
    parameter int unsigned MAX_EXTENTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tuser: req_type
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic         s_axis_tuser,
    // tdata: ext_index[3:0], ext_virt_off, ext_len, ext_data_off, req_off,
    // req_len (64 bits each), zero pad to 328
    input  logic [327:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tuser: seg_valid, seg_is_overlay
    output logic [1:0]   m_axis_tuser,
    // tdata: seg_off, seg_len, seg_data_off (64 bits each)
    output logic [191:0] m_axis_tdata,
    output logic         m_axis_tlast,
    // config write: index 0 virtual_size, 1 extent_count
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_addr,
    input  logic [63:0]  i_cfg_data
);
    import erm_pkg::*;

    logic [W-1:0] r_vsize;
    logic [4:0]   r_count;
    t_cmd         w_fcmd, w_qcmd;
    logic         w_full, w_qvalid, w_pop, w_push;
    logic         w_sv, w_ovl;
    logic [W-1:0] w_off, w_len, w_dat;

    assign o_cfg_ready = 1'b1;

    // take config writes at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsize <= '0;
            r_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_VSIZE: r_vsize <= i_cfg_data;
                CFG_COUNT: r_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    erm_front u_front (
        .i_type         (s_axis_tuser),
        .i_idx          (s_axis_tdata[3:0]),
        .i_ext_virt_off (s_axis_tdata[67:4]),
        .i_ext_len      (s_axis_tdata[131:68]),
        .i_ext_data_off (s_axis_tdata[195:132]),
        .i_req_off      (s_axis_tdata[259:196]),
        .i_req_len      (s_axis_tdata[323:260]),
        .i_vsize        (r_vsize),
        .o_cmd          (w_fcmd)
    );

    // accept whenever the queue has room
    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    erm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_cmd   (w_qcmd)
    );

    erm_back #(.MAX_EXTENTS(MAX_EXTENTS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ext_count      (r_count),
        .i_q_valid        (w_qvalid),
        .i_q_cmd          (w_qcmd),
        .o_q_pop          (w_pop),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_seg_valid      (w_sv),
        .o_seg_is_overlay (w_ovl),
        .o_seg_off        (w_off),
        .o_seg_len        (w_len),
        .o_seg_data_off   (w_dat),
        .o_seg_last       (m_axis_tlast)
    );

    assign m_axis_tuser = {w_ovl, w_sv};
    assign m_axis_tdata = {w_dat, w_len, w_off};

endmodule
